[rtl/core/dcrc_pkg.sv]
// ----------------------------------------------------------------------------
// dcrc_pkg
// Shared constants, types and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package dcrc_pkg;

    localparam int unsigned DataWidth = 8;
    localparam int unsigned CrcWidth  = 16;

    localparam logic [CrcWidth-1:0] POLY_XMODEM = 16'h1021;
    localparam logic [CrcWidth-1:0] POLY_ALT    = 16'h8408;
    localparam logic [CrcWidth-1:0] CRC_INIT    = 16'h0000;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } item_ctrl_t;

    typedef struct packed {
        logic [CrcWidth-1:0] crc_alt;
        logic [CrcWidth-1:0] crc_xmodem;
    } result_t;

    // MSB-first, unreflected, one byte per call
    function automatic logic [CrcWidth-1:0] crc_byte(
        input logic [CrcWidth-1:0]  rem,
        input logic [DataWidth-1:0] data,
        input logic [CrcWidth-1:0]  poly
    );
        logic [CrcWidth-1:0] r;
        r = rem ^ {data, {(CrcWidth-DataWidth){1'b0}}};
        for (int k = 0; k < DataWidth; k++) begin
            if (r[CrcWidth-1]) begin
                r = {r[CrcWidth-2:0], 1'b0} ^ poly;
            end else begin
                r = {r[CrcWidth-2:0], 1'b0};
            end
        end
        return r;
    endfunction

endpackage

[rtl/core/dcrc_in_stage.sv]
// ----------------------------------------------------------------------------
// dcrc_in_stage
// Input register: captures one byte word with its first/last marks.
// ----------------------------------------------------------------------------
module dcrc_in_stage (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dcrc_pkg::DataWidth-1:0]  s_tdata,
    input  logic                            s_tuser,
    input  logic                            s_tlast,
    input  logic                            advance,
    output dcrc_pkg::item_ctrl_t            item_ctrl,
    output logic [dcrc_pkg::DataWidth-1:0]  item_data
);

    logic                           valid_reg, valid_next;
    logic                           first_reg, first_next;
    logic                           last_reg, last_next;
    logic [dcrc_pkg::DataWidth-1:0] data_reg, data_next;
    logic                           accept;

    assign s_tready = !valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        valid_next = valid_reg;
        first_next = first_reg;
        last_next  = last_reg;
        data_next  = data_reg;
        if (accept) begin
            valid_next = 1'b1;
            first_next = s_tuser;
            last_next  = s_tlast;
            data_next  = s_tdata;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        first_reg <= first_next;
        last_reg  <= last_next;
        data_reg  <= data_next;
    end

    assign item_ctrl.valid = valid_reg;
    assign item_ctrl.first = first_reg;
    assign item_ctrl.last  = last_reg;
    assign item_data       = data_reg;

endmodule

[rtl/core/dcrc_engine.sv]
// ----------------------------------------------------------------------------
// dcrc_engine
// Holds both CRC remainders and updates them side by side, one byte a cycle while advance is high.
// ----------------------------------------------------------------------------
module dcrc_engine (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            advance,
    input  dcrc_pkg::item_ctrl_t            item_ctrl,
    input  logic [dcrc_pkg::DataWidth-1:0]  item_data,
    output dcrc_pkg::result_t               result
);

    logic [dcrc_pkg::CrcWidth-1:0] rem_xmodem_reg, rem_xmodem_next;
    logic [dcrc_pkg::CrcWidth-1:0] rem_alt_reg, rem_alt_next;
    logic [dcrc_pkg::CrcWidth-1:0] base_xmodem;
    logic [dcrc_pkg::CrcWidth-1:0] base_alt;
    logic [dcrc_pkg::CrcWidth-1:0] upd_xmodem;
    logic [dcrc_pkg::CrcWidth-1:0] upd_alt;

    assign base_xmodem = item_ctrl.first ? dcrc_pkg::CRC_INIT : rem_xmodem_reg;
    assign base_alt    = item_ctrl.first ? dcrc_pkg::CRC_INIT : rem_alt_reg;
    assign upd_xmodem  = dcrc_pkg::crc_byte(base_xmodem, item_data, dcrc_pkg::POLY_XMODEM);
    assign upd_alt     = dcrc_pkg::crc_byte(base_alt, item_data, dcrc_pkg::POLY_ALT);

    always_comb begin
        rem_xmodem_next = rem_xmodem_reg;
        rem_alt_next    = rem_alt_reg;
        if (advance) begin
            rem_xmodem_next = upd_xmodem;
            rem_alt_next    = upd_alt;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_xmodem_reg <= dcrc_pkg::CRC_INIT;
            rem_alt_reg    <= dcrc_pkg::CRC_INIT;
        end else begin
            rem_xmodem_reg <= rem_xmodem_next;
            rem_alt_reg    <= rem_alt_next;
        end
    end

    assign result.crc_xmodem = upd_xmodem;
    assign result.crc_alt    = upd_alt;

endmodule

[rtl/core/dcrc_out_stage.sv]
// ----------------------------------------------------------------------------
// dcrc_out_stage
// Result register: holds one finished CRC pair until the receiver takes it.
// ----------------------------------------------------------------------------
module dcrc_out_stage (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  dcrc_pkg::result_t       result,
    output logic                    slot_free,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [31:0]             m_tdata
);

    logic              valid_reg, valid_next;
    dcrc_pkg::result_t data_reg, data_next;

    assign slot_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (load) begin
            valid_next = 1'b1;
            data_next  = result;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {data_reg.crc_alt, data_reg.crc_xmodem};

endmodule

[rtl/core/dual_crc16_byte_stream.sv]
// ----------------------------------------------------------------------------
// dual_crc16_byte_stream
// Dual CRC-16 (polynomials 0x1021 and 0x8408, init 0, MSB first) over bytes.
// ----------------------------------------------------------------------------
// Input stream (s_): one message byte per word. s_tuser marks the first byte
// of a message and clears both CRCs before that byte; s_tlast marks the final
// byte. A byte without a first mark continues the current remainders, also
// after a result has been sent.
// Output stream (m_): one word per message, sent for the byte marked last,
// carrying CRC-16/XMODEM in the low half and the 0x8408 CRC in the high half.
// An accepted byte lands in the input register; the combinational
// byte-wide CRC update sits between it and the result (m_tvalid) register.
// Throughput: one byte per cycle unless a last byte waits on a held result.
// Receiver stall: bytes keep flowing into the remainders while a result
// waits; only a following last byte waits in the input register, and
// s_tready drops once that register cannot advance.
// Reset: aresetn (synchronous, active low) clears both remainders to zero
// and empties the input and result registers.
// ----------------------------------------------------------------------------
module dual_crc16_byte_stream (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] first_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [15:0] crc_xmodem, [31:16] crc_alt
);

    dcrc_pkg::item_ctrl_t           item_ctrl;
    logic [dcrc_pkg::DataWidth-1:0] item_data;
    dcrc_pkg::result_t              result;
    logic                           slot_free;
    logic                           advance;
    logic                           load;

    assign advance = item_ctrl.valid && (!item_ctrl.last || slot_free);
    assign load    = advance && item_ctrl.last;

    dcrc_in_stage u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .advance   (advance),
        .item_ctrl (item_ctrl),
        .item_data (item_data)
    );

    dcrc_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item_ctrl (item_ctrl),
        .item_data (item_data),
        .result    (result)
    );

    dcrc_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .result    (result),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

[rtl/core/dcrc_checker.sv]
// ----------------------------------------------------------------------------
// dcrc_checker
// Port-level checks for dual_crc16_byte_stream, bound to the top level.
// ----------------------------------------------------------------------------
module dcrc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tuser,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed under stall");

    // stalled input word holds
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable({s_tdata, s_tuser, s_tlast}))
        else $error("input word changed under stall");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid set after reset");

    // input only backs up behind a stalled result
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("s_tready low without output stall");

    // a new result comes from a last byte that advanced in the previous cycle
    a_new_result: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tready))
        else $error("result appeared without input advance");

endmodule

bind dual_crc16_byte_stream dcrc_checker u_dcrc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

[tb/tb_dual_crc16_byte_stream.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dual_crc16_byte_stream
// Self-checking bench: streams byte messages with random gaps and receiver
// stalls, keeps its own bitwise CRC-16 (0x1021 and 0x8408) remainders per
// accepted word and compares every result word field by field, in order.
// ----------------------------------------------------------------------------
module tb_dual_crc16_byte_stream;

    typedef struct {
        logic [dcrc_pkg::DataWidth-1:0] data;
        logic                           first;
        logic                           last;
        int unsigned                    gap;
    } byte_item_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    byte_item_t          byte_q[$];
    dcrc_pkg::result_t   crc_pair_q[$];

    logic [dcrc_pkg::CrcWidth-1:0] xmodem_rem = dcrc_pkg::CRC_INIT;
    logic [dcrc_pkg::CrcWidth-1:0] alt_rem    = dcrc_pkg::CRC_INIT;

    int unsigned err_cnt      = 0;
    int unsigned accepted_cnt = 0;
    int unsigned total_cnt    = 0;
    int unsigned gap_left     = 0;
    int unsigned stall_left   = 0;
    int unsigned run_left     = 0;
    int unsigned results_seen = 0;
    bit          long_hold_done = 1'b0;
    logic        rdy_next;
    byte_item_t  cur;
    dcrc_pkg::result_t got;
    dcrc_pkg::result_t want;
    dcrc_pkg::result_t pair;

    dual_crc16_byte_stream u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // bit-serial form: feedback is the top remainder bit xor the incoming bit
    function automatic logic [dcrc_pkg::CrcWidth-1:0] crc16_absorb_byte(
        input logic [dcrc_pkg::CrcWidth-1:0]  crc,
        input logic [dcrc_pkg::DataWidth-1:0] b,
        input logic [dcrc_pkg::CrcWidth-1:0]  poly
    );
        logic [dcrc_pkg::CrcWidth-1:0] c;
        logic                          fb;
        c = crc;
        for (int i = dcrc_pkg::DataWidth - 1; i >= 0; i--) begin
            fb = c[dcrc_pkg::CrcWidth-1] ^ b[i];
            c  = {c[dcrc_pkg::CrcWidth-2:0], 1'b0} ^ (fb ? poly : '0);
        end
        return c;
    endfunction

    // mostly short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic push_byte(input logic [7:0] d, input logic f, input logic l,
                             input int unsigned g);
        byte_item_t it;
        it.data  = d;
        it.first = f;
        it.last  = l;
        it.gap   = g;
        byte_q.push_back(it);
    endtask

    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_cnt++;
    endtask

    // sender: presents queued words, updates the CRC prediction on accept
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                if (s_tuser) begin
                    xmodem_rem = dcrc_pkg::CRC_INIT;
                    alt_rem    = dcrc_pkg::CRC_INIT;
                end
                xmodem_rem = crc16_absorb_byte(xmodem_rem, s_tdata, dcrc_pkg::POLY_XMODEM);
                alt_rem    = crc16_absorb_byte(alt_rem, s_tdata, dcrc_pkg::POLY_ALT);
                if (s_tlast) begin
                    pair.crc_xmodem = xmodem_rem;
                    pair.crc_alt    = alt_rem;
                    crc_pair_q.push_back(pair);
                end
                accepted_cnt++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (byte_q.size() != 0) begin
                    cur = byte_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= cur.data;
                    s_tuser  <= cur.first;
                    s_tlast  <= cur.last;
                    gap_left = cur.gap;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: checks result words, drives random and one long back-pressure
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                results_seen++;
                if (crc_pair_q.size() == 0) begin
                    report_error($sformatf("unexpected result word %08h", m_tdata));
                end else begin
                    want = crc_pair_q.pop_front();
                    if (got.crc_xmodem !== want.crc_xmodem)
                        report_error($sformatf("crc_xmodem got %04h exp %04h",
                                               got.crc_xmodem, want.crc_xmodem));
                    if (got.crc_alt !== want.crc_alt)
                        report_error($sformatf("crc_alt got %04h exp %04h",
                                               got.crc_alt, want.crc_alt));
                end
            end
            if (!long_hold_done && results_seen >= 20) begin
                long_hold_done = 1'b1;
                stall_left     = 500;
                run_left       = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                rdy_next = 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                rdy_next = 1'b1;
            end else begin
                run_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120)
                                                         : $urandom_range(0, 4);
                stall_left = pick_gap();
                rdy_next   = 1'b1;
            end
            m_tready <= rdy_next;
        end
    end

    initial begin
        logic [7:0]  check_str[9];
        int unsigned len;
        int unsigned n;
        bit          quiet;

        check_str = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};

        // no first mark right after reset: continues from the reset remainders
        push_byte(8'h31, 1'b0, 1'b0, pick_gap());
        push_byte(8'h32, 1'b0, 1'b1, pick_gap());
        // standard check string
        for (int i = 0; i < 9; i++)
            push_byte(check_str[i], i == 0, i == 8, pick_gap());
        // byte after a result without first mark extends the previous message
        push_byte(8'hA5, 1'b0, 1'b1, pick_gap());
        // single-byte messages at the data extremes
        push_byte(8'h00, 1'b1, 1'b1, pick_gap());
        push_byte(8'hFF, 1'b1, 1'b1, pick_gap());
        push_byte(8'h80, 1'b1, 1'b1, 0);
        push_byte(8'h01, 1'b1, 1'b1, 0);
        // restart in the middle of an unfinished message
        push_byte(8'h55, 1'b1, 1'b0, pick_gap());
        push_byte(8'hAA, 1'b0, 1'b0, pick_gap());
        push_byte(8'h5A, 1'b1, 1'b0, pick_gap());
        push_byte(8'hC3, 1'b0, 1'b1, pick_gap());

        while (byte_q.size() < 720) begin
            if ($urandom_range(0, 99) < 85) begin
                len   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                                    : $urandom_range(1, 8);
                quiet = ($urandom_range(0, 4) == 0);
                for (int i = 0; i < len; i++)
                    push_byte(8'($urandom_range(0, 255)), i == 0, i == len - 1,
                              quiet ? 0 : pick_gap());
            end else begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++)
                    push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), pick_gap());
            end
        end
        total_cnt = byte_q.size();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        while (accepted_cnt < total_cnt) @(posedge aclk);
        while (crc_pair_q.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);

        if (err_cnt == 0) begin
            $display("dual_crc16_byte_stream verification clean");
        end else begin
            $display("dual_crc16_byte_stream verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("dual_crc16_byte_stream verification failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/dcrc_pkg.sv
rtl/core/dcrc_in_stage.sv
rtl/core/dcrc_engine.sv
rtl/core/dcrc_out_stage.sv
rtl/core/dual_crc16_byte_stream.sv
rtl/core/dcrc_checker.sv
tb/tb_dual_crc16_byte_stream.sv
